// ----- hw/rtl/dsl_pkg.sv -----
// Shared constants, command and status codes, and control/status structs
// for the descending sorted list table. No dependencies.
`default_nettype none

package dsl_pkg;

  localparam int unsigned KEY_W            = 32;
  localparam int unsigned CMD_W            = 3;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned COUNT_W          = 7;
  localparam int unsigned DEFAULT_CAPACITY = 64;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic                load;       // latch cmd and key, reset status
    logic                scan_find;  // scan for equal key from the head
    logic                scan_ins;   // scan for insert slot from entry one
    logic                shr_start;  // open a slot at pos (shift right)
    logic                shl_start;  // close the slot at pos (shift left)
    logic                pos_zero;   // start position is the head
    logic                place;      // write key at pos, count up
    logic                drop;       // count down
    logic                clear;      // empty the list
    logic                set_found;
    logic                status_we;
    logic [STATUS_W-1:0] status;
    logic                rsp_load;   // capture the result beat
  } dsl_ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             ins_head;
    logic             scan_done;
    logic             scan_hit;
    logic             shift_done;
  } dsl_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dsl_if.sv -----
// Valid/ready channel interfaces for the command and response beats.
// Depends on dsl_pkg.
`default_nettype none

interface dsl_cmd_if;
  import dsl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface dsl_rsp_if;
  import dsl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic                    found;
  logic signed [KEY_W-1:0] first_value;
  logic                    is_empty;
  logic [COUNT_W-1:0]      count;

  modport source (output valid, output status, output found, output first_value,
                  output is_empty, output count, input ready);
  modport sink   (input valid, input status, input found, input first_value,
                  input is_empty, input count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dsl_datapath.sv -----
// Datapath: entry memory, walk engine for scans and shifts, count, head
// copy and the response register. Depends on dsl_pkg.
`default_nettype none

module dsl_datapath #(
  parameter int unsigned CAPACITY = dsl_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire dsl_pkg::dsl_ctl_t                 ctl_i,
  output dsl_pkg::dsl_sts_t                      sts_o,
  input  wire logic [dsl_pkg::CMD_W-1:0]         cmd_i,
  input  wire logic signed [dsl_pkg::KEY_W-1:0]  key_i,
  output logic [dsl_pkg::STATUS_W-1:0]           status_o,
  output logic                                   found_o,
  output logic signed [dsl_pkg::KEY_W-1:0]       first_value_o,
  output logic                                   is_empty_o,
  output logic [dsl_pkg::COUNT_W-1:0]            count_o
);
  import dsl_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_FIND = 3'd1;
  localparam logic [2:0] MODE_INS  = 3'd2;
  localparam logic [2:0] MODE_SHR  = 3'd3;
  localparam logic [2:0] MODE_SHL  = 3'd4;

  logic [KEY_W-1:0]        mem [CAPACITY];

  logic [CMD_W-1:0]        cmd_q;
  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] head_q;
  logic signed [KEY_W-1:0] rdata_q;
  logic [CW-1:0]           count_q, count_d;
  logic [AW-1:0]           pos_q;
  logic [2:0]              mode_q, mode_d;
  logic [AW-1:0]           ptr_q, ptr_d;
  logic [CW-1:0]           rem_q, rem_d;
  logic                    rv_q, rv_d;
  logic [AW-1:0]           rtag_q;
  logic [STATUS_W-1:0]     status_q;
  logic                    found_q;

  logic                    scanning, shifting, hit, issue;
  logic                    scan_done, shift_done;
  logic [CW-1:0]           scan_pos;
  logic [AW-1:0]           start_pos;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [KEY_W-1:0]        wr_data;

  assign scanning   = (mode_q == MODE_FIND) || (mode_q == MODE_INS);
  assign shifting   = (mode_q == MODE_SHR) || (mode_q == MODE_SHL);
  // insert slot: first entry not greater than the key
  assign hit        = scanning && rv_q &&
                      ((mode_q == MODE_INS) ? !(key_q < rdata_q) : (rdata_q == key_q));
  assign scan_done  = scanning && (hit || (!rv_q && rem_q == '0));
  assign shift_done = shifting && !rv_q && (rem_q == '0);
  assign issue      = (shifting || (scanning && !hit)) && (rem_q != '0);
  assign scan_pos   = hit ? CW'(rtag_q) : count_q;
  assign start_pos  = ctl_i.pos_zero ? '0 : scan_pos[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rtag_q;
    wr_data = rdata_q;
    if (ctl_i.place) begin
      wr_en   = 1'b1;
      wr_addr = pos_q;
      wr_data = key_q;
    end else if (shifting && rv_q) begin
      wr_en   = 1'b1;
      wr_addr = (mode_q == MODE_SHR) ? rtag_q + 1'b1 : rtag_q - 1'b1;
    end
  end

  // Walk engine: one read issued per cycle, data compared or written back
  // in the following cycle.
  always_comb begin
    mode_d  = mode_q;
    ptr_d   = ptr_q;
    rem_d   = rem_q;
    rv_d    = 1'b0;
    count_d = count_q;
    if (ctl_i.scan_find) begin
      mode_d = MODE_FIND;
      ptr_d  = '0;
      rem_d  = count_q;
    end else if (ctl_i.scan_ins) begin
      mode_d = MODE_INS;
      ptr_d  = AW'(1);
      rem_d  = count_q - 1'b1;
    end else if (ctl_i.shr_start) begin
      mode_d = MODE_SHR;
      ptr_d  = AW'(count_q - 1'b1);
      rem_d  = count_q - CW'(start_pos);
    end else if (ctl_i.shl_start) begin
      mode_d = MODE_SHL;
      ptr_d  = start_pos + 1'b1;
      rem_d  = count_q - 1'b1 - CW'(start_pos);
    end else if (scan_done || ctl_i.place || ctl_i.drop) begin
      mode_d = MODE_IDLE;
    end else if (issue) begin
      ptr_d = (mode_q == MODE_SHR) ? ptr_q - 1'b1 : ptr_q + 1'b1;
      rem_d = rem_q - 1'b1;
      rv_d  = 1'b1;
    end
    if (ctl_i.clear) begin
      count_d = '0;
    end else if (ctl_i.place) begin
      count_d = count_q + 1'b1;
    end else if (ctl_i.drop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      ptr_q   <= '0;
      rem_q   <= '0;
      rv_q    <= 1'b0;
      count_q <= '0;
    end else begin
      mode_q  <= mode_d;
      ptr_q   <= ptr_d;
      rem_q   <= rem_d;
      rv_q    <= rv_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata_q <= mem[ptr_q];
      rtag_q  <= ptr_q;
    end
    // keep a copy of the head for the response and the insert check
    if (wr_en && wr_addr == '0) begin
      head_q <= wr_data;
    end
    if (ctl_i.shr_start || ctl_i.shl_start) begin
      pos_q <= start_pos;
    end
    if (ctl_i.load) begin
      cmd_q    <= cmd_i;
      key_q    <= key_i;
      status_q <= ST_OK;
      found_q  <= 1'b0;
    end else begin
      if (ctl_i.status_we) begin
        status_q <= ctl_i.status;
      end
      if (ctl_i.set_found) begin
        found_q <= 1'b1;
      end
    end
    if (ctl_i.rsp_load) begin
      status_o      <= status_q;
      found_o       <= found_q;
      first_value_o <= (count_q == '0) ? '0 : head_q;
      is_empty_o    <= (count_q == '0);
      count_o       <= COUNT_W'(count_q);
    end
  end

  always_comb begin
    sts_o.cmd        = cmd_q;
    sts_o.full       = (count_q == CW'(CAPACITY));
    sts_o.empty      = (count_q == '0);
    sts_o.ins_head   = (count_q == '0) || (head_q < key_q);
    sts_o.scan_done  = scan_done;
    sts_o.scan_hit   = hit;
    sts_o.shift_done = shift_done;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dsl_ctrl.sv -----
// Controller: sequences accept, decode, scan, shift and response for one
// command beat at a time. Depends on dsl_pkg.
`default_nettype none

module dsl_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  input  wire dsl_pkg::dsl_sts_t sts_i,
  output dsl_pkg::dsl_ctl_t      ctl_o
);
  import dsl_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.cmd) inside
          CMD_PUSH, CMD_INSERT: begin
            if (sts_i.full) begin
              ctl_o.status_we = 1'b1;
              ctl_o.status    = ST_FULL;
              state_d         = S_DONE;
            end else if (sts_i.cmd == CMD_PUSH || sts_i.ins_head) begin
              ctl_o.shr_start = 1'b1;
              ctl_o.pos_zero  = 1'b1;
              state_d         = S_SHIFT;
            end else begin
              ctl_o.scan_ins = 1'b1;
              state_d        = S_SCAN;
            end
          end
          CMD_REMOVE, CMD_SEARCH: begin
            ctl_o.scan_find = 1'b1;
            state_d         = S_SCAN;
          end
          CMD_POP: begin
            if (sts_i.empty) begin
              ctl_o.status_we = 1'b1;
              ctl_o.status    = ST_EMPTY;
              state_d         = S_DONE;
            end else begin
              ctl_o.shl_start = 1'b1;
              ctl_o.pos_zero  = 1'b1;
              state_d         = S_SHIFT;
            end
          end
          CMD_CLEAR: begin
            ctl_o.clear = 1'b1;
            state_d     = S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          if (sts_i.cmd == CMD_INSERT) begin
            ctl_o.shr_start = 1'b1;
            state_d         = S_SHIFT;
          end else if (sts_i.cmd == CMD_REMOVE) begin
            if (sts_i.scan_hit) begin
              ctl_o.set_found = 1'b1;
              ctl_o.shl_start = 1'b1;
              state_d         = S_SHIFT;
            end else begin
              ctl_o.status_we = 1'b1;
              ctl_o.status    = ST_NOTFOUND;
              state_d         = S_DONE;
            end
          end else begin
            ctl_o.set_found = sts_i.scan_hit;
            state_d         = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_done) begin
          if (sts_i.cmd == CMD_PUSH || sts_i.cmd == CMD_INSERT) begin
            ctl_o.place = 1'b1;
          end else begin
            ctl_o.drop = 1'b1;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the response register is free
        if (!out_valid_q || out_ready_i) begin
          ctl_o.rsp_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.rsp_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/descending_sorted_list_table_core.sv -----
// Top level of the descending sorted list table: controller plus datapath.
// Depends on dsl_pkg, dsl_if, dsl_ctrl and dsl_datapath.
//
// Usage: each beat on in_i carries a command (push front, ordered insert,
// remove, search, pop, clear) and a signed 32-bit key. Each accepted beat
// gives exactly one beat on out_o with status, found flag, head value,
// empty flag and entry count after the command.
// Timing: one command is worked at a time. Keys live in a single-port-read
// memory walked one entry per cycle. Clear, unused codes and rejected
// push/insert/pop go from decode straight to the result; search scans,
// remove scans and shifts, insert scans (unless the key goes to the head)
// and shifts, push and pop only shift. in_i.ready is high again in the
// cycle the result appears, so a new beat is accepted only after the last
// result is registered.
// Reset clears the entry count and all control state; the memory is not
// cleared and entries above the count are never read.
// A stalled receiver holds the result in the output register; the next
// command is still accepted and worked, and its result waits until the
// output register is free.

`default_nettype none

module descending_sorted_list_table_core #(
  parameter int unsigned CAPACITY = dsl_pkg::DEFAULT_CAPACITY
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dsl_cmd_if.sink   in_i,
  dsl_rsp_if.source out_o
);
  import dsl_pkg::*;

  dsl_ctl_t ctl;
  dsl_sts_t sts;

  dsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  dsl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .cmd_i         (in_i.cmd),
    .key_i         (in_i.key),
    .status_o      (out_o.status),
    .found_o       (out_o.found),
    .first_value_o (out_o.first_value),
    .is_empty_o    (out_o.is_empty),
    .count_o       (out_o.count)
  );

  // an accepted beat keeps in_i.ready low in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("accepted a command while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_FULL) |-> (out_o.count == COUNT_W'(CAPACITY)))
    else $error("full status with list not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_EMPTY) |-> out_o.is_empty)
    else $error("empty status with entries present");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && CAPACITY < 128) |-> (out_o.is_empty == (out_o.count == '0)))
    else $error("empty flag disagrees with count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.found) |-> (out_o.status == ST_OK))
    else $error("found flag with error status");

endmodule

`default_nettype wire
